FILE: src/glcs_pkg.sv
// shared types, constants and font table for the glyph to lcd command stream unit
// no dependencies; imported by every module of the block

package glcs_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_ROWS  = 8;
  localparam int GLYPH_PIX   = GLYPH_COLS * GLYPH_ROWS;
  localparam int GLYPH_COUNT = 95;
  localparam int ITEM_COUNT  = 11 + GLYPH_PIX;
  localparam int IDX_W       = $clog2(ITEM_COUNT);

  localparam logic [7:0] GLYPH_FIRST = 8'h20;
  localparam logic [7:0] GLYPH_LAST  = 8'h7E;
  localparam logic [7:0] BYTE_MASK   = 8'hFF;
  localparam logic [15:0] X_SPAN     = 16'(GLYPH_COLS - 1);
  localparam logic [15:0] Y_SPAN     = 16'(GLYPH_ROWS - 1);

  localparam logic [7:0] CMD_CASET = 8'h2A;
  localparam logic [7:0] CMD_RASET = 8'h2B;
  localparam logic [7:0] CMD_RAMWR = 8'h2C;

  typedef enum logic [1:0] {
    KIND_CMD   = 2'd0,
    KIND_PARAM = 2'd1,
    KIND_PIXEL = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0]  char_code;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] fg_color;
    logic [15:0] bg_color_in;
  } request_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] value;
    logic        last;
  } result_t;

  // one classified character, ready for the back end
  typedef struct packed {
    logic [15:0]          x;
    logic [15:0]          x_end;
    logic [15:0]          y;
    logic [15:0]          y_end;
    logic [15:0]          fg;
    logic [15:0]          bg;
    logic [GLYPH_PIX-1:0] pix;
  } glcs_job_t;

  // column bytes c0..c4 from high to low; bit n of a byte is row n
  localparam logic [39:0] FONT_ROM [GLYPH_COUNT] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0000000000, 40'h0000000000,
    40'h0000000000, 40'h0000000000, 40'h0000000000, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h085454543C,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0836414100,
    40'h00007F0000, 40'h0041413608, 40'h0804081008
  };

  // pixel bits in output order: bit r*5+c is row r of column c
  function automatic logic [GLYPH_PIX-1:0] glyph_pixels(input logic [7:0] code);
    logic [39:0]          cols;
    logic [GLYPH_PIX-1:0] pix;
    logic [7:0]           offs;
    offs = code - GLYPH_FIRST;
    if (code >= GLYPH_FIRST && code <= GLYPH_LAST) begin
      cols = FONT_ROM[offs[6:0]];
    end else begin
      cols = '0;
    end
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      for (int c = 0; c < GLYPH_COLS; c++) begin
        pix[r*GLYPH_COLS + c] = cols[39 - 8*c - 7 + r];
      end
    end
    return pix;
  endfunction

endpackage

FILE: src/glyph_to_lcd_command_stream_unit.sv
// top level of the glyph to lcd command stream unit
// depends on glcs_pkg, glcs_front, glcs_queue, glcs_back

// Each request transfer (push while full is low) draws one 5x8 character: the
// unit emits column-set 0x2A with x and x+4, row-set 0x2B with y and y+7 (high
// byte then low byte, ends wrap at 16 bits), memory-write 0x2C, then 40 pixel
// words row by row, five columns per row, with last set on the final pixel.
// Codes outside 0x20..0x7E and the unused punctuation slots draw blank. Each
// character is 51 results on the result port, one result per cycle while pop
// stays high, walked out by the sequencer behind the output register. A
// request goes through the job queue and the sequencer to the output register;
// up to QUEUE_DEPTH requests wait in the job queue while a character is drawn.
module glyph_to_lcd_command_stream_unit #(
  parameter int QUEUE_DEPTH = glcs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  glcs_pkg::request_t request,
  output logic               empty,
  input  logic               pop,
  output glcs_pkg::result_t  result
);
  import glcs_pkg::*;

  glcs_job_t fe_job;
  glcs_job_t q_job;
  logic      q_valid;
  logic      q_pop;

  glcs_front u_front (
    .request (request),
    .job     (fe_job)
  );

  glcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (fe_job),
    .full   (full),
    .pop    (q_pop),
    .valid  (q_valid),
    .rd_job (q_job)
  );

  glcs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job       (q_job),
    .job_pop   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

`ifndef SYNTH
  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queue or result not cleared by reset");

  a_last_is_pixel: assert property (@(posedge clk) disable iff (rst)
    !empty && result.last |-> result.kind == KIND_PIXEL)
    else $error("last flag on a non-pixel result");

  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    pop && !empty && !result.last |=> !empty)
    else $error("gap inside a character stream");

  a_next_starts_caset: assert property (@(posedge clk) disable iff (rst)
    pop && !empty && result.last |=> empty ||
      (result.kind == KIND_CMD && result.value == {8'h00, CMD_CASET}))
    else $error("character does not start with column-set");
`endif

endmodule

FILE: src/glcs_front.sv
// front end: classifies a character request into a job (glyph bits, window ends)
// depends on glcs_pkg

module glcs_front (
  input  glcs_pkg::request_t  request,
  output glcs_pkg::glcs_job_t job
);
  import glcs_pkg::*;

  always_comb begin
    job.x     = request.pos_x;
    job.x_end = request.pos_x + X_SPAN;
    job.y     = request.pos_y;
    job.y_end = request.pos_y + Y_SPAN;
    job.fg    = request.fg_color;
    job.bg    = request.bg_color_in;
    job.pix   = glyph_pixels(request.char_code);
  end

endmodule

FILE: src/glcs_queue.sv
// short job queue between the front end and the sequencer
// depends on glcs_pkg

module glcs_queue #(
  parameter int DEPTH = glcs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  glcs_pkg::glcs_job_t wr_job,
  output logic                full,
  input  logic                pop,
  output logic                valid,
  output glcs_pkg::glcs_job_t rd_job
);
  import glcs_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  glcs_job_t        slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign valid   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rd_job  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

endmodule

FILE: src/glcs_back.sv
// back end: walks one job through its 51 result items into the output register
// depends on glcs_pkg

module glcs_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  input  glcs_pkg::glcs_job_t job,
  output logic                job_pop,
  output logic                empty,
  input  logic                pop,
  output glcs_pkg::result_t   result
);
  import glcs_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(ITEM_COUNT - 1);
  localparam logic [IDX_W-1:0] PIX_FIRST = IDX_W'(11);

  glcs_job_t        cur;
  logic             busy;
  logic [IDX_W-1:0] idx;
  logic             out_valid;
  result_t          out_r;
  result_t          item_next;
  logic             advance;
  logic             load;

  assign advance = busy && (!out_valid || pop);
  assign load    = job_valid && (!busy || (advance && idx == LAST_IDX));
  assign job_pop = load;
  assign empty   = !out_valid;
  assign result  = out_r;

  always_comb begin
    item_next.kind  = KIND_PARAM;
    item_next.value = '0;
    item_next.last  = 1'b0;
    unique case (idx)
      IDX_W'(0): begin
        item_next.kind  = KIND_CMD;
        item_next.value = {8'h00, CMD_CASET};
      end
      IDX_W'(1):  item_next.value = {8'h00, cur.x[15:8]};
      IDX_W'(2):  item_next.value = {8'h00, cur.x[7:0] & BYTE_MASK};
      IDX_W'(3):  item_next.value = {8'h00, cur.x_end[15:8]};
      IDX_W'(4):  item_next.value = {8'h00, cur.x_end[7:0]};
      IDX_W'(5): begin
        item_next.kind  = KIND_CMD;
        item_next.value = {8'h00, CMD_RASET};
      end
      IDX_W'(6):  item_next.value = {8'h00, cur.y[15:8]};
      IDX_W'(7):  item_next.value = {8'h00, cur.y[7:0]};
      IDX_W'(8):  item_next.value = {8'h00, cur.y_end[15:8]};
      IDX_W'(9):  item_next.value = {8'h00, cur.y_end[7:0]};
      IDX_W'(10): begin
        item_next.kind  = KIND_CMD;
        item_next.value = {8'h00, CMD_RAMWR};
      end
      default: begin
        item_next.kind  = KIND_PIXEL;
        item_next.value = cur.pix[0] ? cur.fg : cur.bg;
        item_next.last  = (idx == LAST_IDX);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        if (idx == LAST_IDX) begin
          busy <= load;
          idx  <= '0;
        end else begin
          idx <= idx + 1'b1;
        end
      end else if (load) begin
        busy <= 1'b1;
        idx  <= '0;
      end
    end
  end

  // glyph bits shift out one per pixel transfer
  always_ff @(posedge clk) begin
    if (load) begin
      cur <= job;
    end else if (advance && idx >= PIX_FIRST) begin
      cur.pix <= cur.pix >> 1;
    end
    if (advance) begin
      out_r <= item_next;
    end
  end

endmodule

FILE: tb/glcs_stream_checker.sv
`timescale 1ns / 100ps
// stream checker for the glyph to lcd command stream unit: predicts the write
// stream of every request transfer and compares each result transfer with it
// depends on glcs_pkg for the port types and the kind codes

module glcs_stream_checker
  import glcs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  logic     full,
  input  request_t request,
  input  logic     empty,
  input  logic     pop,
  input  result_t  result,
  output int       fails,
  output int       pending
);

  localparam logic [7:0]  OP_COLUMN_SET   = 8'h2A;
  localparam logic [7:0]  OP_ROW_SET      = 8'h2B;
  localparam logic [7:0]  OP_MEMORY_WRITE = 8'h2C;
  localparam logic [7:0]  FIRST_GLYPH     = 8'h20;
  localparam logic [7:0]  LAST_GLYPH      = 8'h7E;
  localparam logic [15:0] COL_SPAN        = 16'd4;
  localparam logic [15:0] ROW_SPAN        = 16'd7;
  localparam int          NUM_ROWS        = 8;
  localparam int          NUM_COLS        = 5;
  localparam int          MAX_REPORTS     = 20;

  // column bytes per code from 0x20, column 0 in the top byte; bit n is row n
  localparam logic [39:0] FONT [95] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0000000000, 40'h0000000000,
    40'h0000000000, 40'h0000000000, 40'h0000000000, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h085454543C,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0836414100,
    40'h00007F0000, 40'h0041413608, 40'h0804081008
  };

  result_t wire_stream_q[$];
  result_t want;
  int      char_no;
  int      beat_no;

  initial begin
    fails   = 0;
    pending = 0;
    char_no = 0;
    beat_no = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want_v);
    if (fails < MAX_REPORTS) begin
      $display("%0t: character %0d transfer %0d: %s is 0x%0h, should be 0x%0h",
               $time, char_no, beat_no, what, got, want_v);
    end
    fails++;
  endtask

  function automatic void add_beat(input kind_t k, input logic [15:0] v, input logic fin);
    result_t e;
    e.kind  = k;
    e.value = v;
    e.last  = fin;
    wire_stream_q.push_back(e);
  endfunction

  // address window: opcode, then start and end, high byte first; end wraps at 16 bits
  function automatic void add_window(input logic [7:0] op, input logic [15:0] first,
                                     input logic [15:0] span);
    logic [15:0] stop;
    stop = first + span;
    add_beat(KIND_CMD, {8'h00, op}, 1'b0);
    add_beat(KIND_PARAM, {8'h00, first[15:8]}, 1'b0);
    add_beat(KIND_PARAM, {8'h00, first[7:0]}, 1'b0);
    add_beat(KIND_PARAM, {8'h00, stop[15:8]}, 1'b0);
    add_beat(KIND_PARAM, {8'h00, stop[7:0]}, 1'b0);
  endfunction

  function automatic void draw_character(input request_t req);
    logic [39:0] cols;
    logic        lit;
    // control codes, the unused punctuation slots and 0x7f up come out blank
    if (req.char_code >= FIRST_GLYPH && req.char_code <= LAST_GLYPH) begin
      cols = FONT[req.char_code - FIRST_GLYPH];
    end else begin
      cols = '0;
    end
    add_window(OP_COLUMN_SET, req.pos_x, COL_SPAN);
    add_window(OP_ROW_SET, req.pos_y, ROW_SPAN);
    add_beat(KIND_CMD, {8'h00, OP_MEMORY_WRITE}, 1'b0);
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        lit = cols[32 - 8*c + r];
        add_beat(KIND_PIXEL, lit ? req.fg_color : req.bg_color_in,
                 (r == NUM_ROWS - 1) && (c == NUM_COLS - 1));
      end
    end
  endfunction

  // the result side is checked first: a result never belongs to a request of the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        if (wire_stream_q.size() == 0) begin
          report_mismatch("result with nothing waiting, value", result.value, 0);
        end else begin
          want = wire_stream_q.pop_front();
          if (result.kind !== want.kind) report_mismatch("kind", result.kind, want.kind);
          if (result.value !== want.value) report_mismatch("value", result.value, want.value);
          if (result.last !== want.last) report_mismatch("last", result.last, want.last);
          if (want.last) begin
            char_no++;
            beat_no = 0;
          end else begin
            beat_no++;
          end
        end
      end
      if (push && !full) draw_character(request);
    end
    pending <= wire_stream_q.size();
  end

endmodule

FILE: tb/tb_glyph_to_lcd_command_stream_unit.sv
`timescale 1ns / 100ps
// top of the testbench for the glyph to lcd command stream unit: drives requests
// and result pops under changing idle rates and gives the verdict
// depends on glcs_pkg, the unit itself and glcs_stream_checker

module tb_glyph_to_lcd_command_stream_unit;
  import glcs_pkg::*;

  localparam int STALL_LIMIT      = 5000;
  localparam int TAIL_CYCLES      = 60;
  localparam int RANDOM_PER_PHASE = 27;

  logic     clk     = 1'b0;
  logic     rst     = 1'b1;
  logic     push    = 1'b0;
  logic     pop     = 1'b0;
  request_t request = '0;
  logic     full;
  logic     empty;
  result_t  result;
  int       fails;
  int       pending;
  int       send_idle_pct = 23;
  int       recv_idle_pct = 84;

  glyph_to_lcd_command_stream_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .request (request),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  glcs_stream_checker checker_i (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .request (request),
    .empty   (empty),
    .pop     (pop),
    .result  (result),
    .fails   (fails),
    .pending (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver: a fresh pop decision every cycle
  initial begin
    forever begin
      @(posedge clk);
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic request_t make_req(input logic [7:0] code, input logic [15:0] x,
                                        input logic [15:0] y, input logic [15:0] fg,
                                        input logic [15:0] bg);
    request_t r;
    r.char_code   = code;
    r.pos_x       = x;
    r.pos_y       = y;
    r.fg_color    = fg;
    r.bg_color_in = bg;
    return r;
  endfunction

  // positions lean toward the top of the range so the window ends wrap often
  function automatic logic [15:0] random_coord();
    int pick;
    pick = $urandom_range(99);
    if (pick < 20) return 16'hFFFF - 16'($urandom_range(9));
    if (pick < 30) return 16'($urandom_range(15));
    return 16'($urandom_range(65535));
  endfunction

  function automatic request_t random_request();
    request_t r;
    if ($urandom_range(99) < 75) r.char_code = 8'($urandom_range(8'h7E, 8'h20));
    else r.char_code = 8'($urandom_range(255));
    r.pos_x       = random_coord();
    r.pos_y       = random_coord();
    r.fg_color    = 16'($urandom_range(65535));
    r.bg_color_in = ($urandom_range(9) == 0) ? r.fg_color : 16'($urandom_range(65535));
    return r;
  endfunction

  // push stays high from one transfer to the next unless an idle cycle comes up
  task automatic send_request(input request_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    push    <= 1'b1;
    request <= r;
    do @(posedge clk); while (full);
  endtask

  task automatic wait_for_drain();
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic random_phase();
    for (int i = 0; i < RANDOM_PER_PHASE; i++) send_request(random_request());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // field extremes, window end wrap, blank codes and glyph neighbors
    send_request(make_req(8'h41, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000));
    send_request(make_req(8'h00, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF));
    send_request(make_req(8'h1F, 16'hFFFB, 16'hFFF8, 16'h1234, 16'hABCD));
    send_request(make_req(8'h20, 16'hFFFC, 16'hFFF9, 16'hFFFF, 16'h5555));
    send_request(make_req(8'h21, 16'h00FF, 16'hFF00, 16'hAAAA, 16'h5555));
    send_request(make_req(8'h3A, 16'h0001, 16'h0002, 16'hF800, 16'h07E0));
    send_request(make_req(8'h3E, 16'h7FFF, 16'h8000, 16'h001F, 16'hFFE0));
    send_request(make_req(8'h3F, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000));
    send_request(make_req(8'h7E, 16'hFFFD, 16'hFFFE, 16'h0000, 16'hFFFF));
    send_request(make_req(8'h7F, 16'h0010, 16'h0020, 16'hFFFF, 16'h0000));
    send_request(make_req(8'h80, 16'h1234, 16'h5678, 16'hFFFF, 16'h8421));
    send_request(make_req(8'hFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000));
    send_request(make_req(8'h23, 16'h0040, 16'h0050, 16'h7BEF, 16'h7BEF));
    send_request(make_req(8'h40, 16'hFFFA, 16'hFFF7, 16'h0F0F, 16'hF0F0));
    send_request(make_req(8'h5A, 16'h00F0, 16'h000F, 16'hFFFF, 16'h0000));
    send_request(make_req(8'h7A, 16'h0100, 16'h00FB, 16'h0001, 16'h8000));
    send_request(make_req(8'h30, 16'hC3C3, 16'h3C3C, 16'hFFFF, 16'h0000));
    send_request(make_req(8'h57, 16'h5555, 16'hAAAA, 16'hF800, 16'h07E0));
    random_phase();

    // every expected result must be out before the rates change
    wait_for_drain();
    send_idle_pct = 84;
    recv_idle_pct = 23;
    random_phase();

    wait_for_drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase();

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
